// ----- rtl/core/swgc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swgc_pkg: shared types and constants for the scrolling gradient colorizer
// Field widths, derived widths, item types and the register map.
// ----------------------------------------------------------------------------
package swgc_pkg;

  localparam int MAX_PIXELS = 1024;
  localparam int MAX_STOPS  = 4;

  localparam int IDX_W       = 10;
  localparam int CH_W        = 8;
  localparam int NCH         = 3;
  localparam int COLOR_W     = 24;
  localparam int STOPS_CFG_W = 3;
  localparam int LEN_CFG_W   = 11;
  localparam int DIR_W       = 2;
  localparam int FRAC_W      = 16;
  localparam int NUM_COLOR_REGS = 4;

  localparam int OFF_W  = $clog2(MAX_PIXELS);
  localparam int LEN_W  = $clog2(MAX_PIXELS + 1);
  localparam int CMP_W  = ((LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W) + 1;
  localparam int CNT_W  = $clog2(MAX_STOPS + 1);
  localparam int SX_W   = (CNT_W > STOPS_CFG_W) ? CNT_W : STOPS_CFG_W;
  localparam int SEG_W  = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int PROD_W = OFF_W + CNT_W;
  localparam int DIVD_W = PROD_W + FRAC_W;
  localparam int QBITS  = FRAC_W + SEG_W;
  localparam int SH_W   = (QBITS > OFF_W) ? QBITS : OFF_W;
  localparam int STEP_W = $clog2(SH_W + 1);
  localparam int CMUL_W = CH_W + FRAC_W + 2;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int DATA_W    = 32;
  localparam int NUM_REGS  = 7;
  localparam int ADDR_W    = $clog2(NUM_REGS) + 2;
  localparam int REG_IDX_W = ADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_NUM_STOPS,
    REG_STRIP_LENGTH,
    REG_SCROLL_DIR,
    REG_STOP_COLOR_0,
    REG_STOP_COLOR_1,
    REG_STOP_COLOR_2,
    REG_STOP_COLOR_3
  } reg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic             advance;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } out_item_t;

  typedef struct packed {
    logic [STOPS_CFG_W-1:0]  num_stops;
    logic [LEN_CFG_W-1:0]    strip_length;
    logic signed [DIR_W-1:0] scroll_direction;
  } cfg_t;

  typedef logic [MAX_STOPS-1:0][COLOR_W-1:0] stop_colors_t;

  typedef struct packed {
    logic             black;
    logic [OFF_W-1:0] pos;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [LEN_W-1:0]  divisor;
    logic [LEN_W-1:0]  rem_init;
    logic [SH_W-1:0]   bits;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SH_W-1:0]  quo;
    logic [LEN_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_CFG_W-1:0] raw);
    logic [CMP_W-1:0] r;
    r = CMP_W'(raw);
    if (r > CMP_W'(MAX_PIXELS)) return LEN_W'(MAX_PIXELS);
    return LEN_W'(r);
  endfunction

  function automatic logic [CNT_W-1:0] eff_stops(input logic [STOPS_CFG_W-1:0] raw);
    logic [SX_W-1:0] r;
    r = SX_W'(raw);
    if (r == '0) return CNT_W'(1);
    if (r > SX_W'(MAX_STOPS)) return CNT_W'(MAX_STOPS);
    return CNT_W'(r);
  endfunction

  function automatic logic [CH_W-1:0] chan(input logic [COLOR_W-1:0] c, input int k);
    return c[(NCH-1-k)*CH_W +: CH_W];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/scrolling_wrap_gradient_color.sv -----
// Scrolling looping gradient colorizer. Each input item names a pixel and may
// advance the scroll offset; it yields one RGB item. The front end takes one
// item at a time while the job queue is not full, and when a shortened strip
// length leaves the stored offset too large, it first reduces it by a 10-step
// serial divide. The back end runs the one-bit-per-cycle restoring divide (18
// steps) that yields gradient segment and 16-bit fraction; black pixels skip
// it. A two-entry job queue sits between the two, and the output register lets
// the next item proceed while a result waits. No clearing pass after reset.
// Configuration via APB at byte address 4*index.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scrolling_wrap_gradient_color: top level
// Register file, front end, job queue, back end and the two dividers.
// ----------------------------------------------------------------------------
module scrolling_wrap_gradient_color (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  swgc_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output swgc_pkg::out_item_t           out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swgc_pkg::ADDR_W-1:0]   paddr,
  input  logic [swgc_pkg::DATA_W-1:0]   pwdata,
  output logic [swgc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import swgc_pkg::*;

  cfg_t         cfg;
  stop_colors_t stop_color;
  logic         wr_en;
  reg_idx_t     reg_idx;
  logic [REG_IDX_W-1:0] color_k;

  logic     job_push;
  job_t     push_job;
  logic     q_full;
  logic     job_pop;
  job_t     pop_job;
  logic     q_empty;
  div_req_t fdiv_req;
  div_rsp_t fdiv_rsp;
  div_req_t bdiv_req;
  div_rsp_t bdiv_rsp;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign color_k = paddr[ADDR_W-1:2] - REG_STOP_COLOR_0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_stops        <= STOPS_CFG_W'(MAX_STOPS > 4 ? 4 : MAX_STOPS);
      cfg.strip_length     <= LEN_CFG_W'(1024);
      cfg.scroll_direction <= DIR_W'(1);
      stop_color           <= '0;
    end else if (wr_en) begin
      if (reg_idx == REG_NUM_STOPS) begin
        cfg.num_stops <= pwdata[STOPS_CFG_W-1:0];
      end
      if (reg_idx == REG_STRIP_LENGTH) begin
        cfg.strip_length <= pwdata[LEN_CFG_W-1:0];
      end
      if (reg_idx == REG_SCROLL_DIR) begin
        cfg.scroll_direction <= $signed(pwdata[DIR_W-1:0]);
      end
      for (int k = 0; k < MAX_STOPS; k++) begin
        if (k < NUM_COLOR_REGS &&
            paddr[ADDR_W-1:2] == REG_IDX_W'(int'(REG_STOP_COLOR_0) + k)) begin
          stop_color[k] <= pwdata[COLOR_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_NUM_STOPS:    prdata = DATA_W'(cfg.num_stops);
      REG_STRIP_LENGTH: prdata = DATA_W'(cfg.strip_length);
      REG_SCROLL_DIR:   prdata = DATA_W'($unsigned(cfg.scroll_direction));
      REG_STOP_COLOR_0, REG_STOP_COLOR_1, REG_STOP_COLOR_2, REG_STOP_COLOR_3: begin
        if (int'(color_k) < MAX_STOPS) prdata = DATA_W'(stop_color[SEG_W'(color_k)]);
      end
      default: prdata = '0;
    endcase
  end

  swgc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .job_valid (job_push),
    .job       (push_job),
    .q_full    (q_full),
    .div_req   (fdiv_req),
    .div_rsp   (fdiv_rsp)
  );

  swgc_div u_front_div (
    .clk (clk),
    .rst (rst),
    .req (fdiv_req),
    .rsp (fdiv_rsp)
  );

  swgc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (job_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  swgc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .stop_color (stop_color),
    .job_valid  (!q_empty),
    .job        (pop_job),
    .job_pop    (job_pop),
    .div_req    (bdiv_req),
    .div_rsp    (bdiv_rsp),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  swgc_div u_back_div (
    .clk (clk),
    .rst (rst),
    .req (bdiv_req),
    .rsp (bdiv_rsp)
  );

endmodule
`default_nettype wire

// ----- rtl/core/swgc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swgc_div: serial restoring divider
// One quotient bit per cycle; dividend bits enter MSB first from a shift reg.
// ----------------------------------------------------------------------------
module swgc_div (
  input  logic                clk,
  input  logic                rst,
  input  swgc_pkg::div_req_t  req,
  output swgc_pkg::div_rsp_t  rsp
);
  import swgc_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] left;
  logic [SH_W-1:0]   bits;
  logic [SH_W-1:0]   quo;
  logic [LEN_W-1:0]  rem;
  logic [LEN_W-1:0]  divisor;
  logic [LEN_W:0]    trial;
  logic              take;

  assign trial = {rem, bits[SH_W-1]};
  assign take  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        left    <= req.steps;
        rem     <= req.rem_init;
        bits    <= req.bits;
        divisor <= req.divisor;
        quo     <= '0;
      end else if (busy) begin
        rem  <= take ? LEN_W'(trial - {1'b0, divisor}) : trial[LEN_W-1:0];
        bits <= bits << 1;
        quo  <= {quo[SH_W-2:0], take};
        left <= left - 1'b1;
        if (left == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule
`default_nettype wire

// ----- rtl/core/swgc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swgc_queue: small job FIFO
// Decouples the offset/position front end from the gradient back end.
// ----------------------------------------------------------------------------
module swgc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  swgc_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output swgc_pkg::job_t pop_job,
  output logic           empty
);
  import swgc_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = count == QCNT_W'(QDEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/swgc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swgc_front: item intake and scroll offset
// Reduces the scroll offset when needed, advances it on request, then queues the wrapped position.
// ----------------------------------------------------------------------------
module swgc_front (
  input  logic               clk,
  input  logic               rst,
  input  swgc_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  swgc_pkg::in_item_t in_item,
  output logic               job_valid,
  output swgc_pkg::job_t     job,
  input  logic               q_full,
  output swgc_pkg::div_req_t div_req,
  input  swgc_pkg::div_rsp_t div_rsp
);
  import swgc_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_PREP, F_MOD, F_ADV, F_PUSH} fstate_t;

  fstate_t          state;
  logic [IDX_W-1:0] idx;
  logic             adv;
  logic [OFF_W-1:0] off;
  logic [OFF_W-1:0] scroll_offset;

  logic [LEN_W-1:0]        len;
  logic [CMP_W-1:0]        len_c;
  logic                    len_zero;
  logic                    off_big;
  logic signed [CMP_W-1:0] lens;
  logic signed [CMP_W-1:0] t0;
  logic signed [CMP_W-1:0] t1;
  logic signed [CMP_W-1:0] t2;
  logic [OFF_W-1:0]        off_next;
  logic [CMP_W-1:0]        idx_c;
  logic [CMP_W-1:0]        so_c;

  assign len      = eff_len(cfg.strip_length);
  assign len_c    = CMP_W'(len);
  assign len_zero = len == '0;
  assign off_big  = CMP_W'(scroll_offset) >= len_c;

  assign lens = $signed(len_c);
  assign t0   = $signed({{(CMP_W-OFF_W){1'b0}}, off})
              + $signed({{(CMP_W-DIR_W){cfg.scroll_direction[DIR_W-1]}}, cfg.scroll_direction});
  assign t1   = (t0 < 0) ? t0 + lens : t0;
  assign t2   = (t1 < 0) ? t1 + lens : ((t1 >= lens) ? t1 - lens : t1);
  assign off_next = adv ? OFF_W'($unsigned(t2)) : off;

  assign idx_c = CMP_W'(idx);
  assign so_c  = CMP_W'(scroll_offset);

  assign in_ready  = (state == F_IDLE) && !q_full;
  assign job_valid = state == F_PUSH;
  assign job.black = idx_c >= len_c;
  assign job.pos   = (idx_c >= so_c) ? OFF_W'(idx_c - so_c) : OFF_W'(idx_c + len_c - so_c);

  assign div_req.start    = (state == F_PREP) && !len_zero && off_big;
  assign div_req.divisor  = len;
  assign div_req.rem_init = '0;
  assign div_req.bits     = SH_W'(scroll_offset) << (SH_W - OFF_W);
  assign div_req.steps    = STEP_W'(OFF_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      scroll_offset <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            idx   <= in_item.pixel_index;
            adv   <= in_item.advance;
            state <= F_PREP;
          end
        end
        F_PREP: begin
          if (len_zero) begin
            scroll_offset <= '0;
            state         <= F_PUSH;
          end else if (off_big) begin
            state <= F_MOD;
          end else begin
            off   <= scroll_offset;
            state <= F_ADV;
          end
        end
        F_MOD: begin
          if (div_rsp.done) begin
            off   <= div_rsp.rem[OFF_W-1:0];
            state <= F_ADV;
          end
        end
        F_ADV: begin
          scroll_offset <= off_next;
          state         <= F_PUSH;
        end
        F_PUSH: begin
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/swgc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swgc_back: gradient segment, fraction and color blend
// Divides pos*stops<<16 by the length, picks two stops and blends per channel.
// ----------------------------------------------------------------------------
module swgc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  swgc_pkg::cfg_t         cfg,
  input  swgc_pkg::stop_colors_t stop_color,
  input  logic                   job_valid,
  input  swgc_pkg::job_t         job,
  output logic                   job_pop,
  output swgc_pkg::div_req_t     div_req,
  input  swgc_pkg::div_rsp_t     div_rsp,
  output logic                   out_valid,
  input  logic                   out_ready,
  output swgc_pkg::out_item_t    out_item
);
  import swgc_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_START, B_DIV, B_RDA, B_RDB, B_MUL, B_OUT} bstate_t;

  bstate_t             state;
  logic                black;
  logic [OFF_W-1:0]    pos;
  logic [SEG_W-1:0]    seg;
  logic [FRAC_W-1:0]   frac;
  logic [COLOR_W-1:0]  color_a;
  logic [COLOR_W-1:0]  color_b;
  logic signed [CMUL_W-1:0] prodc [NCH];

  logic [CNT_W-1:0]    n;
  logic [PROD_W-1:0]   prod;
  logic [DIVD_W-1:0]   dividend;
  logic [CNT_W-1:0]    seg_p1;
  logic [SEG_W-1:0]    nxt;
  logic [SEG_W-1:0]    rd_sel;
  logic [COLOR_W-1:0]  color_rd;
  logic [CH_W-1:0]     sum [NCH];
  logic                can_load;

  assign n        = eff_stops(cfg.num_stops);
  assign prod     = PROD_W'(pos) * PROD_W'(n);
  assign dividend = {prod, {FRAC_W{1'b0}}};
  assign seg_p1   = CNT_W'(seg) + 1'b1;
  assign nxt      = (seg_p1 == n) ? '0 : SEG_W'(seg_p1);
  assign rd_sel   = (state == B_RDA) ? seg : nxt;
  assign color_rd = stop_color[rd_sel];
  assign can_load = !out_valid || out_ready;
  assign job_pop  = (state == B_IDLE) && job_valid;

  assign div_req.start    = state == B_START;
  assign div_req.divisor  = eff_len(cfg.strip_length);
  assign div_req.rem_init = LEN_W'(dividend >> QBITS);
  assign div_req.bits     = SH_W'(dividend[QBITS-1:0]) << (SH_W - QBITS);
  assign div_req.steps    = STEP_W'(QBITS);

  always_comb begin
    logic signed [CMUL_W-1:0] acc;
    for (int c = 0; c < NCH; c++) begin
      acc    = $signed({{(CMUL_W-CH_W){1'b0}}, chan(color_a, c)}) + (prodc[c] >>> FRAC_W);
      sum[c] = acc[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != B_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            black <= job.black;
            pos   <= job.pos;
            state <= job.black ? B_OUT : B_START;
          end
        end
        B_START: state <= B_DIV;
        B_DIV: begin
          if (div_rsp.done) begin
            seg   <= div_rsp.quo[FRAC_W +: SEG_W];
            frac  <= div_rsp.quo[FRAC_W-1:0];
            state <= B_RDA;
          end
        end
        B_RDA: begin
          color_a <= color_rd;
          state   <= B_RDB;
        end
        B_RDB: begin
          color_b <= color_rd;
          state   <= B_MUL;
        end
        B_MUL: begin
          for (int c = 0; c < NCH; c++) begin
            prodc[c] <= ($signed({1'b0, chan(color_b, c)}) - $signed({1'b0, chan(color_a, c)}))
                      * $signed({1'b0, frac});
          end
          state <= B_OUT;
        end
        B_OUT: begin
          if (can_load) begin
            out_valid      <= 1'b1;
            out_item.red   <= black ? '0 : sum[0];
            out_item.green <= black ? '0 : sum[1];
            out_item.blue  <= black ? '0 : sum[2];
            state          <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/swgc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swgc_checker: port-level checks for the gradient colorizer
// Watches the item handshakes at the top-level ports.
// ----------------------------------------------------------------------------
module swgc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input swgc_pkg::out_item_t out_item
);
  import swgc_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed or dropped while stalled");

  // intake is one item at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("front end ready right after accepting an item");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not empty and ready after reset");

endmodule

bind scrolling_wrap_gradient_color swgc_checker u_swgc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
